// ----- hw/rtl/blpg_pkg.sv -----
// Shared types and constants for the Bresenham line point generator.
package blpg_pkg;

    // Coordinate width and derived widths of the decision arithmetic
    localparam int COORD_BITS = 12;
    localparam int ERR_W      = COORD_BITS + 3;   // signed error term / diagonal step
    localparam int INC_S_W    = COORD_BITS + 2;   // straight step, always non-negative

    // Request actions
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    // Input request payload
    typedef struct packed {
        t_action                 action;
        logic [COORD_BITS-1:0]   x_start;
        logic [COORD_BITS-1:0]   y_start;
        logic [COORD_BITS-1:0]   x_end;
        logic [COORD_BITS-1:0]   y_end;
    } t_in_req;

    // Output request payload
    typedef struct packed {
        logic                    point_valid;
        logic [COORD_BITS-1:0]   point_x;
        logic [COORD_BITS-1:0]   point_y;
        logic [COORD_BITS-1:0]   point_index;
        logic                    last_point;
    } t_out_req;

endpackage

// ----- hw/rtl/blpg_in_if.sv -----
// Valid/ready channel carrying line load and step requests.
interface blpg_in_if;
    import blpg_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/blpg_out_if.sv -----
// Valid/ready channel carrying generated line points.
interface blpg_out_if;
    import blpg_pkg::*;

    logic     valid;
    logic     ready;
    t_out_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bresenham_line_point_generator_core.sv -----
// Bresenham line walker: load endpoints, then emit one line point per step request.
// Every request returns exactly one result. The block takes one request per clock unless
// the output stalls; each result passes the input register and then the
// result register. The walk state (position, error term, index) updates with a single
// add and compare per request, so back-to-back steps sustain one point per clock; only
// backpressure on the output channel slows it. A load request or a step with no active
// line returns point_valid = 0 with all other fields zero.
module bresenham_line_point_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpg_in_if.sink     i_in,
    blpg_out_if.source  o_out
);
    import blpg_pkg::*;

    // Input register
    logic     r_s1_valid;
    t_in_req  r_s1_req;

    // Result register
    logic     r_out_valid;
    t_out_req r_out_data;

    // Walk state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_major_end, n_major_end;
    logic [ERR_W-1:0]      r_error_term, n_error_term;
    logic [INC_S_W-1:0]    r_inc_straight, n_inc_straight;
    logic [ERR_W-1:0]      r_inc_diagonal, n_inc_diagonal;
    logic                  r_minor_negative, n_minor_negative;
    logic                  r_y_is_major, n_y_is_major;
    logic                  r_line_active, n_line_active;
    logic [COORD_BITS-1:0] r_step_count, n_step_count;
    t_out_req              n_out_data;

    logic s2_free;
    logic s1_adv;

    // Handshake: result register frees when empty or being drained
    assign s2_free      = !r_out_valid || o_out.ready;
    assign s1_adv       = r_s1_valid && s2_free;
    assign i_in.ready   = !r_s1_valid || s2_free;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out_data;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_req <= i_in.data;
        end
    end

    // Load setup and walk step
    always_comb begin
        logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
        logic [COORD_BITS-1:0] sx, sy, ex, ey;
        logic [COORD_BITS-1:0] major_now;
        logic                  last;
        logic                  diag;

        n_cur_x          = r_cur_x;
        n_cur_y          = r_cur_y;
        n_major_end      = r_major_end;
        n_error_term     = r_error_term;
        n_inc_straight   = r_inc_straight;
        n_inc_diagonal   = r_inc_diagonal;
        n_minor_negative = r_minor_negative;
        n_y_is_major     = r_y_is_major;
        n_line_active    = r_line_active;
        n_step_count     = r_step_count;
        n_out_data       = '0;

        dx = (r_s1_req.x_start > r_s1_req.x_end) ? r_s1_req.x_start - r_s1_req.x_end
                                                 : r_s1_req.x_end - r_s1_req.x_start;
        dy = (r_s1_req.y_start > r_s1_req.y_end) ? r_s1_req.y_start - r_s1_req.y_end
                                                 : r_s1_req.y_end - r_s1_req.y_start;
        sx = r_s1_req.x_start;
        sy = r_s1_req.y_start;
        ex = r_s1_req.x_end;
        ey = r_s1_req.y_end;
        dmaj = dx;
        dmin = dy;

        major_now = r_y_is_major ? r_cur_y : r_cur_x;
        last      = major_now >= r_major_end;
        diag      = !r_error_term[ERR_W-1];

        unique case (r_s1_req.action)
            ACT_LOAD: begin
                n_y_is_major = dy > dx;
                // Start from the lower end of the major axis
                if (n_y_is_major) begin
                    if (!(r_s1_req.y_start < r_s1_req.y_end)) begin
                        sx = r_s1_req.x_end;   sy = r_s1_req.y_end;
                        ex = r_s1_req.x_start; ey = r_s1_req.y_start;
                    end
                    n_minor_negative = ex < sx;
                    n_major_end      = ey;
                    dmaj             = dy;
                    dmin             = dx;
                end else begin
                    if (!(r_s1_req.x_start < r_s1_req.x_end)) begin
                        sx = r_s1_req.x_end;   sy = r_s1_req.y_end;
                        ex = r_s1_req.x_start; ey = r_s1_req.y_start;
                    end
                    n_minor_negative = ey < sy;
                    n_major_end      = ex;
                end
                n_cur_x        = sx;
                n_cur_y        = sy;
                n_error_term   = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
                n_inc_straight = {1'b0, dmin, 1'b0};
                n_inc_diagonal = {2'b00, dmin, 1'b0} - {2'b00, dmaj, 1'b0};
                n_step_count   = '0;
                n_line_active  = 1'b1;
            end
            ACT_STEP: begin
                if (r_line_active) begin
                    n_out_data.point_valid = 1'b1;
                    n_out_data.point_x     = r_cur_x;
                    n_out_data.point_y     = r_cur_y;
                    n_out_data.point_index = r_step_count;
                    n_out_data.last_point  = last;
                    if (last) begin
                        n_line_active = 1'b0;
                    end else begin
                        // Major axis always advances; minor only on a diagonal step
                        if (r_y_is_major) begin
                            n_cur_y = r_cur_y + 1'b1;
                            if (diag) begin
                                n_cur_x = r_minor_negative ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                            end
                        end else begin
                            n_cur_x = r_cur_x + 1'b1;
                            if (diag) begin
                                n_cur_y = r_minor_negative ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                            end
                        end
                        n_error_term = diag ? r_error_term + r_inc_diagonal
                                            : r_error_term + {1'b0, r_inc_straight};
                        n_step_count = r_step_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Walk state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_cur_x          <= '0;
            r_cur_y          <= '0;
            r_major_end      <= '0;
            r_error_term     <= '0;
            r_inc_straight   <= '0;
            r_inc_diagonal   <= '0;
            r_minor_negative <= 1'b0;
            r_y_is_major     <= 1'b0;
            r_line_active    <= 1'b0;
            r_step_count     <= '0;
        end else begin
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_cur_x          <= n_cur_x;
                r_cur_y          <= n_cur_y;
                r_major_end      <= n_major_end;
                r_error_term     <= n_error_term;
                r_inc_straight   <= n_inc_straight;
                r_inc_diagonal   <= n_inc_diagonal;
                r_minor_negative <= n_minor_negative;
                r_y_is_major     <= n_y_is_major;
                r_line_active    <= n_line_active;
                r_step_count     <= n_step_count;
            end
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- hw/rtl/blpg_checker.sv -----
// Port-level checks for the Bresenham line point generator, bound to the top level.
module blpg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  blpg_pkg::t_out_req i_out_data
);
    import blpg_pkg::*;

    // Nothing is offered in the cycle after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // A stalled result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result holds its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

    // Results without a point carry all-zero fields
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.point_valid |->
            i_out_data.point_x == '0 && i_out_data.point_y == '0 &&
            i_out_data.point_index == '0 && !i_out_data.last_point)
        else $error("empty result carries nonzero fields");

    // The last-point mark only rides on a real point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last_point |-> i_out_data.point_valid)
        else $error("last point flagged without a point");

endmodule

bind bresenham_line_point_generator_core blpg_checker u_blpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the Bresenham line point generator core.
module testbench;
    import blpg_pkg::*;

    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int ITEM_GOAL  = 1200;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 20;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        t_in_req req;
        bit      drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    blpg_in_if  req_if ();
    blpg_out_if pt_if ();

    bresenham_line_point_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (pt_if.source)
    );

    // Requests waiting to be offered, and points still owed by the block
    t_pending pending_q[$];
    t_out_req point_q[$];

    int item_n;
    int offered_n;
    int taken_n;
    int points_seen;
    int fail_n;
    int idle_cycles;

    // Walk state of the predictor
    logic [COORD_BITS-1:0] walk_x;
    logic [COORD_BITS-1:0] walk_y;
    logic [COORD_BITS-1:0] walk_end;
    logic [COORD_BITS-1:0] walk_idx;
    int                    walk_err;
    int                    walk_inc_s;
    int                    walk_inc_d;
    bit                    walk_minor_neg;
    bit                    walk_y_major;
    bit                    walk_active;

    // Sender and receiver pacing
    int  burst_left;
    int  gap_left;
    int  run_left;
    bit  rx_open;
    int  hold_left;
    bit  hold_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Predicts the point returned for one request and updates the walk
    function automatic t_out_req next_point(input t_in_req r);
        t_out_req              res;
        int                    dx;
        int                    dy;
        int                    dmaj;
        int                    dmin;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COORD_BITS-1:0] major_now;
        res = '0;
        if (r.action == ACT_LOAD) begin
            dx = int'(r.x_start) - int'(r.x_end);
            dy = int'(r.y_start) - int'(r.y_end);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            walk_y_major = dy > dx;
            // start at the lower end of the major axis
            if (walk_y_major ? (r.y_start < r.y_end) : (r.x_start < r.x_end)) begin
                sx = r.x_start; sy = r.y_start; ex = r.x_end; ey = r.y_end;
            end else begin
                sx = r.x_end; sy = r.y_end; ex = r.x_start; ey = r.y_start;
            end
            if (walk_y_major) begin
                walk_minor_neg = ex < sx;
                walk_end       = ey;
                dmaj           = dy;
                dmin           = dx;
            end else begin
                walk_minor_neg = ey < sy;
                walk_end       = ex;
                dmaj           = dx;
                dmin           = dy;
            end
            walk_x      = sx;
            walk_y      = sy;
            walk_err    = 2 * dmin - dmaj;
            walk_inc_s  = 2 * dmin;
            walk_inc_d  = 2 * (dmin - dmaj);
            walk_idx    = '0;
            walk_active = 1'b1;
            return res;
        end
        if (!walk_active) return res;

        major_now       = walk_y_major ? walk_y : walk_x;
        res.point_valid = 1'b1;
        res.point_x     = walk_x;
        res.point_y     = walk_y;
        res.point_index = walk_idx;
        res.last_point  = major_now >= walk_end;
        if (res.last_point) begin
            walk_active = 1'b0;
        end else begin
            // one unit on the major axis, minor axis moves when error is not negative
            if (walk_y_major) walk_y = walk_y + 1'b1;
            else              walk_x = walk_x + 1'b1;
            if (walk_err >= 0) begin
                if (walk_y_major) walk_x = walk_minor_neg ? walk_x - 1'b1 : walk_x + 1'b1;
                else              walk_y = walk_minor_neg ? walk_y - 1'b1 : walk_y + 1'b1;
                walk_err = walk_err + walk_inc_d;
            end else begin
                walk_err = walk_err + walk_inc_s;
            end
            walk_idx = walk_idx + 1'b1;
        end
        return res;
    endfunction

    task automatic push_req(input t_action act, input int xa, input int ya,
                            input int xb, input int yb, input bit drain);
        t_pending p;
        p.req.action  = act;
        p.req.x_start = COORD_BITS'(xa);
        p.req.y_start = COORD_BITS'(ya);
        p.req.x_end   = COORD_BITS'(xb);
        p.req.y_end   = COORD_BITS'(yb);
        p.drain       = drain;
        pending_q.push_back(p);
        item_n++;
    endtask

    // Step request; the endpoint fields are don't-care and get random bits
    task automatic push_step();
        push_req(ACT_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 1'b0);
    endtask

    task automatic push_line(input int xa, input int ya, input int xb, input int yb,
                             input int n_steps, input bit drain);
        push_req(ACT_LOAD, xa, ya, xb, yb, drain);
        repeat (n_steps) push_step();
    endtask

    // Two coordinates d apart, often pushed against the edges of the range
    task automatic place(input int d, output int a, output int b);
        int lo;
        case ($urandom_range(0, 7))
            0:       lo = 0;
            1:       lo = COORD_MAX - d;
            default: lo = $urandom_range(0, COORD_MAX - d);
        endcase
        if ($urandom_range(0, 1)) begin
            a = lo; b = lo + d;
        end else begin
            a = lo + d; b = lo;
        end
    endtask

    task automatic build_directed();
        push_step();                                // no line loaded yet
        push_line(4095, 0, 4095, 0, 2, 1'b0);       // single point, then one step past it
        push_line(4095, 4095, 4093, 4095, 4, 1'b0); // horizontal, right to left
        push_line(0, 2, 0, 0, 4, 1'b0);             // vertical, bottom to top
        push_line(3, 0, 0, 3, 4, 1'b0);             // slope tie, minor decreasing
        push_line(4095, 4095, 4094, 4091, 2, 1'b0); // steep, dropped by the next load
        push_line(0, 0, 4095, 4095, 1, 1'b0);
        push_line(0, 4095, 4095, 0, 1, 1'b0);
    endtask

    task automatic build_random();
        int kind;
        int dmaj;
        int dmin;
        int dx;
        int dy;
        int xa;
        int xb;
        int ya;
        int yb;
        int n_pts;
        int n_steps;
        int line_n;
        line_n = 0;
        while (item_n < ITEM_GOAL) begin
            kind = $urandom_range(0, 9);
            dmaj = ($urandom_range(0, 9) == 0) ? $urandom_range(25, COORD_MAX)
                                               : $urandom_range(0, 24);
            case (kind)
                0:       begin dx = 0;    dy = 0;    end
                1:       begin dx = dmaj; dy = 0;    end
                2:       begin dx = 0;    dy = dmaj; end
                3:       begin dx = dmaj; dy = dmaj; end
                default: begin
                    dmin = $urandom_range(0, dmaj);
                    if ($urandom_range(0, 1)) begin
                        dx = dmaj; dy = dmin;
                    end else begin
                        dx = dmin; dy = dmaj;
                    end
                end
            endcase
            place(dx, xa, xb);
            place(dy, ya, yb);
            n_pts = ((dx > dy) ? dx : dy) + 1;
            case ($urandom_range(0, 19))
                16, 17, 18: n_steps = $urandom_range(0, n_pts - 1);  // dropped early
                19:         n_steps = 0;                             // back-to-back loads
                default:    n_steps = n_pts + $urandom_range(0, 2);  // to the end, up to two past it
            endcase
            if (n_steps > 40) n_steps = $urandom_range(1, 40);
            // sender waits for the block to drain before two of the loads
            push_line(xa, ya, xb, yb, n_steps, line_n == 30 || line_n == 150);
            line_n++;
        end
    endtask

    // Driver: offers requests in bursts separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || taken_n == offered_n) begin
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && point_q.size() != 0)) begin
                req_if.valid <= 1'b0;
            end else begin
                req_if.valid <= 1'b1;
                req_if.data  <= pending_q[0].req;
                void'(pending_q.pop_front());
                offered_n++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: alternating open and stalled runs, plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pt_if.ready <= 1'b0;
        end else if (!hold_done && points_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            pt_if.ready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                rx_open  = !rx_open;
                run_left = rx_open ? (($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                                  : $urandom_range(1, 30))
                                   : $urandom_range(1, 10);
            end
            run_left--;
            pt_if.ready <= rx_open;
        end
    end

    // Monitor: checks each returned point, predicts each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt_if.valid && pt_if.ready) begin
                points_seen++;
                if (point_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("unexpected point: v=%0d x=%0d y=%0d idx=%0d last=%0d",
                                 pt_if.data.point_valid, pt_if.data.point_x,
                                 pt_if.data.point_y, pt_if.data.point_index,
                                 pt_if.data.last_point);
                end else if (pt_if.data.point_valid !== point_q[0].point_valid ||
                             pt_if.data.point_x     !== point_q[0].point_x     ||
                             pt_if.data.point_y     !== point_q[0].point_y     ||
                             pt_if.data.point_index !== point_q[0].point_index ||
                             pt_if.data.last_point  !== point_q[0].last_point) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("point %0d mismatch: exp v=%0d x=%0d y=%0d idx=%0d last=%0d,",
                                 points_seen - 1, point_q[0].point_valid,
                                 point_q[0].point_x, point_q[0].point_y,
                                 point_q[0].point_index, point_q[0].last_point,
                                 " got v=%0d x=%0d y=%0d idx=%0d last=%0d",
                                 pt_if.data.point_valid, pt_if.data.point_x,
                                 pt_if.data.point_y, pt_if.data.point_index,
                                 pt_if.data.last_point);
                end
                if (point_q.size() != 0) void'(point_q.pop_front());
            end
            if (req_if.valid && req_if.ready) begin
                point_q.push_back(next_point(req_if.data));
                taken_n++;
            end
            // watchdog on cycles with no transfer on either channel
            if ((req_if.valid && req_if.ready) || (pt_if.valid && pt_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Reset, stimulus build, end of run
    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        pt_if.ready  = 1'b0;
        item_n       = 0;
        offered_n    = 0;
        taken_n      = 0;
        points_seen  = 0;
        fail_n       = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gap_left     = 0;
        run_left     = 0;
        rx_open      = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
        walk_x       = '0;
        walk_y       = '0;
        walk_end     = '0;
        walk_idx     = '0;
        walk_err     = 0;
        walk_inc_s   = 0;
        walk_inc_d   = 0;
        walk_minor_neg = 1'b0;
        walk_y_major   = 1'b0;
        walk_active    = 1'b0;

        build_directed();
        build_random();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending_q.size() == 0 && taken_n == offered_n && point_q.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(negedge i_clk);
        if (idle_cycles < IDLE_LIMIT)
            repeat (TAIL_WAIT) @(negedge i_clk);
        fail_n = fail_n + point_q.size();

        if (idle_cycles < IDLE_LIMIT && fail_n == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- bresenham_line_point_generator_core.f -----
hw/rtl/blpg_pkg.sv
hw/rtl/blpg_in_if.sv
hw/rtl/blpg_out_if.sv
hw/rtl/bresenham_line_point_generator_core.sv
hw/rtl/blpg_checker.sv
sim/testbench.sv
